@@ rtl/core/rmbb_pkg.sv @@
// ----------------------------------------------------------------------------
// rmbb_pkg: shared types and constants of the rotated mono bitmap blitter
// Panel geometry, register indexes, field widths and the lane result type.
// ----------------------------------------------------------------------------
package rmbb_pkg;

	// Landscape panel; logical portrait space is PANEL_HEIGHT wide, PANEL_WIDTH tall
	localparam int PANEL_WIDTH  = 960;
	localparam int PANEL_HEIGHT = 540;
	localparam int HALF_WIDTH   = PANEL_WIDTH / 2;

	localparam int NUM_LANES = 8;
	localparam int LANE_W    = $clog2(NUM_LANES);

	localparam int ADDR_W  = 18;
	localparam int COLOR_W = 4;
	localparam int COL_W   = 7;
	localparam int ROW_W   = 10;
	localparam int DIM_W   = 11;
	localparam int BPR_W   = 8;
	localparam int ORG_W   = 12;
	localparam int CFG_W   = 12;
	localparam int CFG_IDX_W = 3;

	// Signed working width of logical coordinates
	localparam int COORD_W = 14;
	// Panel row index and address arithmetic widths
	localparam int PY_W    = $clog2(PANEL_HEIGHT);
	localparam int HW_W    = $clog2(HALF_WIDTH + 1);
	localparam int PROD_W  = PY_W + HW_W + 1;

	localparam logic [BPR_W-1:0] BPR_MAX = BPR_W'(128);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BITMAP_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BITMAP_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_ROW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INK_COLOR     = 3'd5;

	// What one lane found for its pixel
	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] addr;
		logic              upper;
	} lane_res_t;

endpackage

@@ rtl/core/rmbb_if.sv @@
// ----------------------------------------------------------------------------
// rmbb_if: request channels of the rotated mono bitmap blitter
// Source byte channel and framebuffer nibble write channel.
// ----------------------------------------------------------------------------
interface rmbb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] bitmap_byte;
	logic       start_of_bitmap;

	modport source (output valid, bitmap_byte, start_of_bitmap, input ready);
	modport sink   (input valid, bitmap_byte, start_of_bitmap, output ready);
endinterface

interface rmbb_write_if;
	logic                          valid;
	logic                          ready;
	logic [rmbb_pkg::ADDR_W-1:0]   write_address;
	logic                          upper_nibble;
	logic [rmbb_pkg::COLOR_W-1:0]  pixel_color;
	logic                          last_of_byte;

	modport source (output valid, write_address, upper_nibble, pixel_color, last_of_byte,
		input ready);
	modport sink   (input valid, write_address, upper_nibble, pixel_color, last_of_byte,
		output ready);
endinterface

@@ rtl/core/rotated_mono_bitmap_blitter.sv @@
// ----------------------------------------------------------------------------
// rotated_mono_bitmap_blitter: 1bpp bitmap to rotated 4bpp framebuffer writes
// Eight pixel lanes test and rotate one source byte; a merge stage
// serializes the surviving pixels into nibble write requests.
// ----------------------------------------------------------------------------
// Usage:
//  - pixels_in carries one source byte per request, rows in order, padding
//    bytes included; start_of_bitmap clears the row/column counters first.
//  - writes_out carries one nibble write request per drawn pixel, leftmost
//    pixel first; last_of_byte marks the final write of a source byte.
//    Bytes that draw nothing produce no request at all.
//  - Config: cfg_write_en/cfg_index/cfg_data, written while the block idles.
//  - Path: accepted bytes pass the input register, lane register and
//    serializer bank; writes leave from the single output register.
//  - Throughput: one write per cycle while writes_out is ready; the
//    serializer drains one byte while the next is tested in the lanes.
//  - Stall: a stalled writes_out holds its request; the serializer, lane
//    register and input register fill, then pixels_in.ready drops.
//  - Reset: counters cleared, all stages empty, registers at 48/48/6/0/0/0.
// ----------------------------------------------------------------------------
module rotated_mono_bitmap_blitter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [rmbb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rmbb_pkg::CFG_W-1:0]          cfg_data,
	rmbb_byte_if.sink                           pixels_in,
	rmbb_write_if.source                        writes_out
);

	// configuration registers
	logic [rmbb_pkg::DIM_W-1:0]        width_q;
	logic [rmbb_pkg::DIM_W-1:0]        height_q;
	logic [rmbb_pkg::BPR_W-1:0]        bpr_q;
	logic signed [rmbb_pkg::ORG_W-1:0] origin_x_q;
	logic signed [rmbb_pkg::ORG_W-1:0] origin_y_q;
	logic [rmbb_pkg::COLOR_W-1:0]      ink_q;

	// source position counters
	logic [rmbb_pkg::COL_W-1:0]        col_q;
	logic [rmbb_pkg::ROW_W-1:0]        row_q;
	logic [rmbb_pkg::COL_W-1:0]        col_cur;
	logic [rmbb_pkg::ROW_W-1:0]        row_cur;
	logic [rmbb_pkg::BPR_W-1:0]        eff_bpr;
	logic                              row_end;

	// stage 1: accepted byte and its position
	logic                              s1_valid_q;
	logic [7:0]                        byte_s1;
	logic [rmbb_pkg::COL_W-1:0]        col_s1;
	logic [rmbb_pkg::ROW_W-1:0]        row_s1;

	// stage 2: lane results
	logic                                          s2_valid_q;
	rmbb_pkg::lane_res_t [rmbb_pkg::NUM_LANES-1:0] lanes_s2;
	rmbb_pkg::lane_res_t [rmbb_pkg::NUM_LANES-1:0] lane_res;

	logic                                take;
	logic                                s2_free;
	logic                                s1_free;
	logic                                accept;
	logic signed [rmbb_pkg::COORD_W-1:0] ly;
	logic                                ly_ok;
	logic                                row_ok;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= rmbb_pkg::DIM_W'(48);
			height_q   <= rmbb_pkg::DIM_W'(48);
			bpr_q      <= rmbb_pkg::BPR_W'(6);
			origin_x_q <= '0;
			origin_y_q <= '0;
			ink_q      <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				rmbb_pkg::REG_BITMAP_WIDTH:  width_q    <= cfg_data[rmbb_pkg::DIM_W-1:0];
				rmbb_pkg::REG_BITMAP_HEIGHT: height_q   <= cfg_data[rmbb_pkg::DIM_W-1:0];
				rmbb_pkg::REG_BYTES_PER_ROW: bpr_q      <= cfg_data[rmbb_pkg::BPR_W-1:0];
				rmbb_pkg::REG_ORIGIN_X:      origin_x_q <= $signed(cfg_data[rmbb_pkg::ORG_W-1:0]);
				rmbb_pkg::REG_ORIGIN_Y:      origin_y_q <= $signed(cfg_data[rmbb_pkg::ORG_W-1:0]);
				rmbb_pkg::REG_INK_COLOR:     ink_q      <= cfg_data[rmbb_pkg::COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// flow control: each stage moves when the one after it frees up
	assign s2_free         = !s2_valid_q || take;
	assign s1_free         = !s1_valid_q || s2_free;
	assign pixels_in.ready = s1_free;
	assign accept          = pixels_in.valid && s1_free;

	// position of the incoming byte; a zero row length acts as one byte,
	// anything past the 7-bit column span is clamped
	always_comb begin
		col_cur = pixels_in.start_of_bitmap ? '0 : col_q;
		row_cur = pixels_in.start_of_bitmap ? '0 : row_q;
		if (bpr_q == '0)
			eff_bpr = rmbb_pkg::BPR_W'(1);
		else if (bpr_q > rmbb_pkg::BPR_MAX)
			eff_bpr = rmbb_pkg::BPR_MAX;
		else
			eff_bpr = bpr_q;
		row_end = ({1'b0, col_cur} + rmbb_pkg::BPR_W'(1)) >= eff_bpr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= row_cur + rmbb_pkg::ROW_W'(1);
			end else begin
				col_q <= col_cur + rmbb_pkg::COL_W'(1);
				row_q <= row_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (s1_free)
			s1_valid_q <= pixels_in.valid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= pixels_in.bitmap_byte;
			col_s1  <= col_cur;
			row_s1  <= row_cur;
		end
	end

	// row terms shared by all lanes; logical y becomes panel x
	always_comb begin
		ly = $signed({{(rmbb_pkg::COORD_W-rmbb_pkg::ORG_W){origin_y_q[rmbb_pkg::ORG_W-1]}},
			origin_y_q}) + $signed({{(rmbb_pkg::COORD_W-rmbb_pkg::ROW_W){1'b0}}, row_s1});
		ly_ok  = !ly[rmbb_pkg::COORD_W-1] &&
			(ly < rmbb_pkg::COORD_W'(rmbb_pkg::PANEL_WIDTH));
		row_ok = {1'b0, row_s1} < height_q;
	end

	// lane i handles bit 7-i, so lane 0 is the leftmost pixel
	for (genvar i = 0; i < rmbb_pkg::NUM_LANES; i++) begin : g_lane
		rmbb_lane u_lane (
			.lane_index   (rmbb_pkg::LANE_W'(i)),
			.pixel_bit    (byte_s1[rmbb_pkg::NUM_LANES-1-i]),
			.row_ok       (row_ok),
			.col          (col_s1),
			.bitmap_width (width_q),
			.origin_x     (origin_x_q),
			.ly           (ly),
			.ly_ok        (ly_ok),
			.res          (lane_res[rmbb_pkg::NUM_LANES-1-i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s2_valid_q <= 1'b0;
		else if (s2_free)
			s2_valid_q <= s1_valid_q;
	end

	always_ff @(posedge clk) begin
		if (s2_free)
			lanes_s2 <= lane_res;
	end

	// merge: MSB lane is stored in the top slot and issued first
	rmbb_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.s2_valid  (s2_valid_q),
		.s2_lanes  (lanes_s2),
		.ink_color (ink_q),
		.take      (take),
		.wr        (writes_out)
	);

endmodule

@@ rtl/core/rmbb_lane.sv @@
// ----------------------------------------------------------------------------
// rmbb_lane: one pixel lane
// Width and clip test of one bit, then rotation onto the panel address.
// ----------------------------------------------------------------------------
module rmbb_lane (
	input  logic [rmbb_pkg::LANE_W-1:0]         lane_index,
	input  logic                                pixel_bit,
	input  logic                                row_ok,
	input  logic [rmbb_pkg::COL_W-1:0]          col,
	input  logic [rmbb_pkg::DIM_W-1:0]          bitmap_width,
	input  logic signed [rmbb_pkg::ORG_W-1:0]   origin_x,
	input  logic signed [rmbb_pkg::COORD_W-1:0] ly,
	input  logic                                ly_ok,
	output rmbb_pkg::lane_res_t                 res
);

	logic [rmbb_pkg::DIM_W-2:0]          x;
	logic signed [rmbb_pkg::COORD_W-1:0] lx;
	logic                                lx_ok;
	logic [rmbb_pkg::COORD_W-1:0]        py_full;
	logic [rmbb_pkg::PY_W-1:0]           py;
	logic [rmbb_pkg::PROD_W-1:0]         prod;

	always_comb begin
		x  = {col, lane_index};
		lx = $signed({{(rmbb_pkg::COORD_W-rmbb_pkg::ORG_W){origin_x[rmbb_pkg::ORG_W-1]}},
			origin_x}) + $signed({{(rmbb_pkg::COORD_W-rmbb_pkg::DIM_W+1){1'b0}}, x});
		lx_ok = !lx[rmbb_pkg::COORD_W-1] &&
			(lx < rmbb_pkg::COORD_W'(rmbb_pkg::PANEL_HEIGHT));

		// rotate: panel row counts down as logical x grows
		py_full = rmbb_pkg::COORD_W'(rmbb_pkg::PANEL_HEIGHT - 1) - lx;
		py      = py_full[rmbb_pkg::PY_W-1:0];
		prod    = rmbb_pkg::PROD_W'(py) * rmbb_pkg::PROD_W'(rmbb_pkg::HALF_WIDTH)
			+ rmbb_pkg::PROD_W'(ly[rmbb_pkg::COORD_W-2:1]);

		res.hit   = pixel_bit && row_ok && ({1'b0, x} < bitmap_width) && lx_ok && ly_ok;
		res.addr  = prod[rmbb_pkg::ADDR_W-1:0];
		res.upper = ly[0];
	end

endmodule

@@ rtl/core/rmbb_merge.sv @@
// ----------------------------------------------------------------------------
// rmbb_merge: lane merge and write serializer
// Holds one byte's lane results, issues them MSB lane first into an output
// register, flagging the final write of the byte.
// ----------------------------------------------------------------------------
module rmbb_merge (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s2_valid,
	input  rmbb_pkg::lane_res_t [rmbb_pkg::NUM_LANES-1:0] s2_lanes,
	input  logic [rmbb_pkg::COLOR_W-1:0]                ink_color,
	output logic                                        take,
	rmbb_write_if.source                                wr
);

	logic [rmbb_pkg::NUM_LANES-1:0]                     mask_q;
	rmbb_pkg::lane_res_t [rmbb_pkg::NUM_LANES-1:0]      bank_q;
	logic [rmbb_pkg::NUM_LANES-1:0]                     hits;
	logic [rmbb_pkg::NUM_LANES-1:0]                     rest;
	logic [rmbb_pkg::LANE_W-1:0]                        sel;
	logic                                               out_free;
	logic                                               emit;

	logic                                               out_valid_q;
	logic [rmbb_pkg::ADDR_W-1:0]                        out_addr_q;
	logic                                               out_upper_q;
	logic [rmbb_pkg::COLOR_W-1:0]                       out_color_q;
	logic                                               out_last_q;

	always_comb begin
		sel = '0;
		for (int i = 0; i < rmbb_pkg::NUM_LANES; i++) begin
			if (mask_q[i])
				sel = rmbb_pkg::LANE_W'(i);
		end
		rest = mask_q & ~(rmbb_pkg::NUM_LANES'(1) << sel);
		for (int i = 0; i < rmbb_pkg::NUM_LANES; i++)
			hits[i] = s2_lanes[i].hit;
		out_free = !out_valid_q || wr.ready;
		emit     = (mask_q != '0) && out_free;
		take     = (mask_q == '0) || (emit && (rest == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (take) begin
			mask_q <= s2_valid ? hits : '0;
		end else if (emit) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (take && s2_valid)
			bank_q <= s2_lanes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (wr.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_addr_q  <= bank_q[sel].addr;
			out_upper_q <= bank_q[sel].upper;
			out_color_q <= ink_color;
			out_last_q  <= (rest == '0);
		end
	end

	assign wr.valid         = out_valid_q;
	assign wr.write_address = out_addr_q;
	assign wr.upper_nibble  = out_upper_q;
	assign wr.pixel_color   = out_color_q;
	assign wr.last_of_byte  = out_last_q;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the rotated mono bitmap blitter
// Source bytes go in on pixels_in; an in-bench model of the row/column
// counters, clipping and 90 degree rotation predicts every nibble write,
// and each write request on writes_out is checked against the oldest one.
// ----------------------------------------------------------------------------
module tb;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 10;
	// Pipeline is 3 deep plus the serializer; bytes that draw nothing leave no trace
	localparam int DRAIN_CYCLES   = 12;
	// Cycles with no request moving on either channel before the run is declared hung
	localparam int WATCHDOG_LIMIT = 5000;
	// Largest bitmap (in bytes) sent in one random burst
	localparam int MAX_BURST      = 48;

	// Indexes past the register list; writes there must be dropped
	localparam logic [rmbb_pkg::CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
	localparam logic [rmbb_pkg::CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

	typedef struct packed {
		logic [rmbb_pkg::ADDR_W-1:0]  addr;
		logic                         upper;
		logic [rmbb_pkg::COLOR_W-1:0] color;
		logic                         last;
	} nibble_write_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_write_en;
	logic [rmbb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rmbb_pkg::CFG_W-1:0]     cfg_data;

	rmbb_byte_if  pixels_in ();
	rmbb_write_if writes_out ();

	rotated_mono_bitmap_blitter DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixels_in    (pixels_in),
		.writes_out   (writes_out)
	);

	// Mirror of the block's registers
	logic [rmbb_pkg::DIM_W-1:0]        bm_width;
	logic [rmbb_pkg::DIM_W-1:0]        bm_height;
	logic [rmbb_pkg::BPR_W-1:0]        row_len;
	logic signed [rmbb_pkg::ORG_W-1:0] org_x;
	logic signed [rmbb_pkg::ORG_W-1:0] org_y;
	logic [rmbb_pkg::COLOR_W-1:0]      ink;

	// Mirror of the source counters
	logic [rmbb_pkg::COL_W-1:0] col_pos;
	logic [rmbb_pkg::ROW_W-1:0] row_pos;

	// Writes predicted but not yet seen, oldest first
	nibble_write_t pending_writes[$];

	int idle_pct;
	int stall_pct;
	int err_count;
	int quiet_cycles;

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	// Work out the nibble writes one accepted source byte causes, then step
	// the column/row counters exactly as the block does.
	function automatic void predict_byte_writes(input logic [7:0] pix, input logic sob);
		nibble_write_t hits[$];
		nibble_write_t w;
		int x;
		int lx;
		int ly;
		int py;
		int row_span;

		if (sob) begin
			col_pos = '0;
			row_pos = '0;
		end
		if (row_pos < bm_height) begin
			for (int b = 0; b < 8; b++) begin
				x  = int'(col_pos) * 8 + b;
				lx = int'(org_x) + x;
				ly = int'(org_y) + int'(row_pos);
				// ink bit, inside the bitmap width, inside the portrait bounds
				if (pix[7-b] && x < bm_width && lx >= 0 && lx < rmbb_pkg::PANEL_HEIGHT &&
						ly >= 0 && ly < rmbb_pkg::PANEL_WIDTH) begin
					// rotate: panel x = logical y, panel y = flipped logical x
					py      = rmbb_pkg::PANEL_HEIGHT - 1 - lx;
					w.addr  = rmbb_pkg::ADDR_W'(py * rmbb_pkg::HALF_WIDTH + ly / 2);
					w.upper = ly[0];
					w.color = ink;
					w.last  = 1'b0;
					hits.push_back(w);
				end
			end
			if (hits.size() > 0)
				hits[hits.size()-1].last = 1'b1;
			foreach (hits[i])
				pending_writes.push_back(hits[i]);
		end

		// zero row length behaves as one byte, anything past 128 as 128
		row_span = (row_len == 0) ? 1 :
			(row_len > rmbb_pkg::BPR_MAX) ? int'(rmbb_pkg::BPR_MAX) : int'(row_len);
		if (int'(col_pos) + 1 >= row_span) begin
			col_pos = '0;
			row_pos = row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1'b1;
		end
	endfunction

	// One register write; the mirror follows the same masking as the block
	task automatic set_register(input logic [rmbb_pkg::CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= rmbb_pkg::CFG_W'(value);
		@(negedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			rmbb_pkg::REG_BITMAP_WIDTH:  bm_width  = value[rmbb_pkg::DIM_W-1:0];
			rmbb_pkg::REG_BITMAP_HEIGHT: bm_height = value[rmbb_pkg::DIM_W-1:0];
			rmbb_pkg::REG_BYTES_PER_ROW: row_len   = value[rmbb_pkg::BPR_W-1:0];
			rmbb_pkg::REG_ORIGIN_X:      org_x     = value[rmbb_pkg::ORG_W-1:0];
			rmbb_pkg::REG_ORIGIN_Y:      org_y     = value[rmbb_pkg::ORG_W-1:0];
			rmbb_pkg::REG_INK_COLOR:     ink       = value[rmbb_pkg::COLOR_W-1:0];
			default: ;
		endcase
	endtask

	// Stop sending, let every predicted write land, then cover bytes that
	// draw nothing but may still sit in the lanes.
	task automatic await_idle();
		@(negedge clk);
		pixels_in.valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input int w, input int h, input int bpr, input int ox,
			input int oy, input int ink_level);
		await_idle();
		set_register(rmbb_pkg::REG_BITMAP_WIDTH, w);
		set_register(rmbb_pkg::REG_BITMAP_HEIGHT, h);
		set_register(rmbb_pkg::REG_BYTES_PER_ROW, bpr);
		set_register(rmbb_pkg::REG_ORIGIN_X, ox);
		set_register(rmbb_pkg::REG_ORIGIN_Y, oy);
		set_register(rmbb_pkg::REG_INK_COLOR, ink_level);
	endtask

	// Present one source byte request; random idle cycles first, with junk
	// payload while valid is low. Returns at the accepting edge.
	task automatic send_byte(input logic [7:0] pix, input logic sob);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			pixels_in.valid           <= 1'b0;
			pixels_in.bitmap_byte     <= 8'($urandom);
			pixels_in.start_of_bitmap <= 1'($urandom);
			@(negedge clk);
		end
		pixels_in.valid           <= 1'b1;
		pixels_in.bitmap_byte     <= pix;
		pixels_in.start_of_bitmap <= sob;
		do
			@(posedge clk);
		while (!pixels_in.ready);
		predict_byte_writes(pix, sob);
	endtask

	// A bitmap: start flag on the first byte, dense ink, and now and then a
	// stray start flag mid-stream to resync the counters early.
	task automatic send_bitmap(input int nbytes);
		logic [7:0] pix;
		logic       sob;

		for (int i = 0; i < nbytes; i++) begin
			pix = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
			sob = (i == 0) || ($urandom_range(15) == 0);
			send_byte(pix, sob);
		end
	endtask

	// Receiver stalls
	always @(negedge clk)
		writes_out.ready <= ($urandom_range(99) >= stall_pct);

	// Check every accepted write request against the oldest prediction
	always @(posedge clk) begin : check_writes
		nibble_write_t exp_w;

		if (arst_n && writes_out.valid && writes_out.ready) begin
			if (pending_writes.size() == 0) begin
				$error("unexpected write request: write_address %0d",
					writes_out.write_address);
				err_count++;
			end else begin
				exp_w = pending_writes.pop_front();
				if (writes_out.write_address !== exp_w.addr) begin
					$error("write_address: expected %0d, got %0d", exp_w.addr,
						writes_out.write_address);
					err_count++;
				end
				if (writes_out.upper_nibble !== exp_w.upper) begin
					$error("upper_nibble: expected %0d, got %0d", exp_w.upper,
						writes_out.upper_nibble);
					err_count++;
				end
				if (writes_out.pixel_color !== exp_w.color) begin
					$error("pixel_color: expected %0d, got %0d", exp_w.color,
						writes_out.pixel_color);
					err_count++;
				end
				if (writes_out.last_of_byte !== exp_w.last) begin
					$error("last_of_byte: expected %0d, got %0d", exp_w.last,
						writes_out.last_of_byte);
					err_count++;
				end
			end
		end
	end

	// Watchdog: any request moving on either channel counts as progress
	always @(posedge clk) begin
		if (!arst_n || (pixels_in.valid && pixels_in.ready) ||
				(writes_out.valid && writes_out.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Reset register values, ink 0, full 48 pixel row of 6 bytes
	task automatic test_reset_values();
		send_byte(8'hFF, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b0);
	endtask

	// Writes to indexes past the list must leave every register alone
	task automatic test_register_writes();
		await_idle();
		set_register(REG_UNUSED_6, 'hFFF);
		set_register(REG_UNUSED_7, 'h000);
		send_byte(8'hC3, 1'b1);
	endtask

	// Width not a multiple of 8, padding bytes, zero width/height,
	// zero row length, rows past the bitmap height
	task automatic test_row_layout();
		configure(13, 3, 3, 100, 200, 15);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		configure(0, 5, 1, 10, 10, 7);
		send_byte(8'hFF, 1'b1);
		configure(8, 0, 1, 10, 10, 7);
		send_byte(8'hFF, 1'b1);
		configure(8, 3, 0, 10, 10, 5);
		send_byte(8'h81, 1'b1);
		send_byte(8'h42, 1'b0);
		send_byte(8'h3C, 1'b0);
		send_byte(8'h18, 1'b0);
	endtask

	// Clipping on all four logical edges, top panel address, origin extremes
	task automatic test_clipping();
		configure(16, 2, 2, 532, 958, 12);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		configure(16, 2, 2, -4, -1, 6);
		send_byte(8'hF0, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h0F, 1'b0);
		// logical x 0, y 959: the last framebuffer byte
		configure(8, 2, 1, 0, 958, 10);
		send_byte(8'h80, 1'b1);
		send_byte(8'h80, 1'b0);
		configure(8, 1, 1, -2048, 2047, 1);
		send_byte(8'hFF, 1'b1);
		configure(8, 1, 1, 2047, -2048, 2);
		send_byte(8'hFF, 1'b1);
	endtask

	// Widest bitmap; a row length of 255 must wrap the column at 128
	task automatic test_wide_rows();
		configure(1024, 1024, 255, -500, 100, 3);
		send_byte(8'($urandom), 1'b1);
		repeat (129) send_byte(8'($urandom), 1'b0);
	endtask

	// Random settings and bitmaps under one idling mode. Mostly small
	// bitmaps placed on the panel; now and then full-range settings.
	task automatic run_random_phase(input int idle, input int stall, input int quota);
		int sent;
		int w;
		int h;
		int bpr;
		int span;
		int n;

		idle_pct  = idle;
		stall_pct = stall;
		sent      = 0;
		while (sent < quota) begin
			if ($urandom_range(7) == 0) begin
				w   = $urandom_range(1, 1024);
				h   = $urandom_range(1, 1024);
				bpr = $urandom_range(0, 255);
				configure(w, h, bpr, $urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 15));
			end else begin
				w   = $urandom_range(1, 48);
				h   = $urandom_range(1, 6);
				bpr = (w + 7) / 8 + $urandom_range(0, 1);
				configure(w, h, bpr, int'($urandom_range(0, 579)) - 20,
					int'($urandom_range(0, 999)) - 20, $urandom_range(0, 15));
			end
			span = (bpr == 0) ? 1 : (bpr > 128) ? 128 : bpr;
			n    = (span * h > MAX_BURST) ? MAX_BURST : span * h;
			repeat ($urandom_range(1, 2)) begin
				send_bitmap(n);
				sent += n;
				// bytes past the last row should draw nothing
				if ($urandom_range(3) == 0) begin
					repeat ($urandom_range(1, 4)) begin
						send_byte(8'($urandom), 1'b0);
						sent++;
					end
				end
			end
		end
	endtask

	initial begin
		arst_n                    = 1'b0;
		cfg_write_en              = 1'b0;
		cfg_index                 = '0;
		cfg_data                  = '0;
		pixels_in.valid           = 1'b0;
		pixels_in.bitmap_byte     = '0;
		pixels_in.start_of_bitmap = 1'b0;
		writes_out.ready          = 1'b0;
		idle_pct                  = 0;
		stall_pct                 = 0;
		err_count                 = 0;
		// register values after reset
		bm_width                  = rmbb_pkg::DIM_W'(48);
		bm_height                 = rmbb_pkg::DIM_W'(48);
		row_len                   = rmbb_pkg::BPR_W'(6);
		org_x                     = '0;
		org_y                     = '0;
		ink                       = '0;
		col_pos                   = '0;
		row_pos                   = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part, no idling on either side
		test_reset_values();
		test_register_writes();
		test_row_layout();
		test_clipping();
		test_wide_rows();

		// random part: no idling, sender idle, receiver stalling, both
		run_random_phase(0, 0, 40);
		run_random_phase(62, 0, 40);
		run_random_phase(0, 62, 40);
		run_random_phase(34, 34, 40);

		await_idle();
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
